FILE: rtl/lscpu_pkg.sv
// ----------------------------------------------------------------------------
// lscpu_pkg
// Shared types and codes of the load/store CPU execute unit: beat payloads,
// action, opcode, funct and status codes, and the execute control bundle.
// ----------------------------------------------------------------------------
package lscpu_pkg;

	// action codes of a command beat
	localparam logic [1:0] ACT_EXEC   = 2'd0;
	localparam logic [1:0] ACT_WR_MEM = 2'd1;
	localparam logic [1:0] ACT_RD_MEM = 2'd2;
	localparam logic [1:0] ACT_RD_REG = 2'd3;

	// opcodes
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_ADDI  = 6'd1;
	localparam logic [5:0] OP_SUBI  = 6'd2;
	localparam logic [5:0] OP_ANDI  = 6'd3;
	localparam logic [5:0] OP_ORI   = 6'd4;
	localparam logic [5:0] OP_SHL   = 6'd5;
	localparam logic [5:0] OP_SHR   = 6'd6;
	localparam logic [5:0] OP_LW    = 6'd7;
	localparam logic [5:0] OP_SW    = 6'd8;
	localparam logic [5:0] OP_BLT   = 6'd9;
	localparam logic [5:0] OP_BEQ   = 6'd10;
	localparam logic [5:0] OP_BNE   = 6'd11;
	localparam logic [5:0] OP_JMP   = 6'd12;

	// R-type funct codes
	localparam logic [5:0] FN_ADD = 6'b010000;
	localparam logic [5:0] FN_SUB = 6'b010001;
	localparam logic [5:0] FN_AND = 6'b010010;
	localparam logic [5:0] FN_OR  = 6'b010011;
	localparam logic [5:0] FN_NOR = 6'b010100;

	// response status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_HALTED    = 2'd1;
	localparam logic [1:0] STS_INV_OP    = 2'd2;
	localparam logic [1:0] STS_INV_FUNCT = 2'd3;

	localparam logic [31:0] HALT_WORD = 32'hFC00_0000;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] instruction_word;
		logic [9:0]  mem_address;
		logic [31:0] write_value;
		logic [4:0]  reg_index;
	} cmd_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [1:0]  status;
		logic [31:0] read_value;
	} rsp_t;

	// decoded effects of one instruction, from the execute logic to the core
	typedef struct packed {
		logic        rf_we;
		logic [4:0]  rf_waddr;
		logic [31:0] rf_wdata;
		logic        dm_we;
		logic        dm_re;
		logic [31:0] ea;
		logic [31:0] dm_wdata;
		logic        pc_we;
		logic        set_halt;
		logic [1:0]  status;
	} exec_t;

endpackage

FILE: rtl/lscpu_regfile.sv
// ----------------------------------------------------------------------------
// lscpu_regfile
// 32 x 32 register file: two registered read ports, one write port.
// Per-entry valid bits make unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module lscpu_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata
);
	logic [31:0] rf_mem [32];
	logic [31:0] vld_q;
	logic        vld_a_q;
	logic        vld_b_q;
	logic [31:0] data_a_q;
	logic [31:0] data_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			rf_mem[waddr] <= wdata;
		end
		if (re) begin
			data_a_q <= rf_mem[raddr_a];
			data_b_q <= rf_mem[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_a_q <= vld_q[raddr_a];
				vld_b_q <= vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = vld_a_q ? data_a_q : '0;
	assign rdata_b = vld_b_q ? data_b_q : '0;

endmodule

FILE: rtl/lscpu_dmem.sv
// ----------------------------------------------------------------------------
// lscpu_dmem
// Single-port synchronous data memory, read data registered. No reset:
// contents are undefined until written.
// ----------------------------------------------------------------------------
module lscpu_dmem #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [31:0]   wdata,
	input  logic          re,
	output logic [31:0]   rdata
);
	logic [31:0] dm_mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			dm_mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= dm_mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lscpu_alu.sv
// ----------------------------------------------------------------------------
// lscpu_alu
// Decode and execute of one instruction word against its two register
// operands: ALU result, effective address, branch/jump target and status.
// ----------------------------------------------------------------------------
module lscpu_alu #(
	parameter int PC_WIDTH = 16
) (
	input  logic [31:0]         word,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [PC_WIDTH-1:0] pc,
	input  logic                halted,
	output logic [PC_WIDTH-1:0] pc_next,
	output lscpu_pkg::exec_t    ex
);
	import lscpu_pkg::*;

	logic [5:0]          op;
	logic [5:0]          fn;
	logic [4:0]          rt;
	logic [4:0]          rd;
	logic [31:0]         imm_sx;
	logic                sh_big;
	logic [31:0]         shl_res;
	logic [31:0]         shr_res;
	logic [PC_WIDTH-1:0] pc_inc;
	logic                take;

	assign op     = word[31:26];
	assign fn     = word[5:0];
	assign rt     = word[20:16];
	assign rd     = word[15:11];
	assign imm_sx = {{16{word[15]}}, word[15:0]};

	// amount is the extended immediate as unsigned: anything >= 32 clears
	assign sh_big  = |imm_sx[31:5];
	assign shl_res = sh_big ? '0 : (a << imm_sx[4:0]);
	assign shr_res = sh_big ? '0 : (a >> imm_sx[4:0]);

	assign pc_inc = pc + PC_WIDTH'(1);

	always_comb begin
		ex          = '0;
		ex.status   = STS_OK;
		ex.ea       = a + imm_sx;
		ex.dm_wdata = b;
		ex.rf_waddr = rt;
		pc_next     = pc_inc;
		take        = 1'b0;
		if (halted) begin
			ex.status = STS_HALTED;
		end else if (word == HALT_WORD) begin
			ex.set_halt = 1'b1;
			ex.status   = STS_HALTED;
		end else if (word == '0) begin
			ex.pc_we = 1'b1;
		end else begin
			case (op)
				OP_RTYPE: begin
					ex.pc_we    = 1'b1;
					ex.rf_waddr = rd;
					ex.rf_we    = 1'b1;
					case (fn)
						FN_ADD: ex.rf_wdata = a + b;
						FN_SUB: ex.rf_wdata = a - b;
						FN_AND: ex.rf_wdata = a & b;
						FN_OR:  ex.rf_wdata = a | b;
						FN_NOR: ex.rf_wdata = ~(a | b);
						default: begin
							ex.rf_we  = 1'b0;
							ex.status = STS_INV_FUNCT;
						end
					endcase
				end
				OP_ADDI: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = a + imm_sx;
				end
				OP_SUBI: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = a - imm_sx;
				end
				OP_ANDI: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = a & imm_sx;
				end
				OP_ORI: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = a | imm_sx;
				end
				OP_SHL: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = shl_res;
				end
				OP_SHR: begin
					ex.pc_we = 1'b1; ex.rf_we = 1'b1; ex.rf_wdata = shr_res;
				end
				OP_LW: begin
					ex.pc_we = 1'b1; ex.dm_re = 1'b1;
				end
				OP_SW: begin
					ex.pc_we = 1'b1; ex.dm_we = 1'b1;
				end
				OP_BLT, OP_BEQ, OP_BNE: begin
					ex.pc_we = 1'b1;
					if (op == OP_BLT) begin
						take = a < b;
					end else if (op == OP_BEQ) begin
						take = a == b;
					end else begin
						take = a != b;
					end
					if (take) begin
						pc_next = pc_inc + PC_WIDTH'(imm_sx);
					end
				end
				OP_JMP: begin
					ex.pc_we = 1'b1;
					pc_next  = PC_WIDTH'(word[25:0]);
				end
				default: begin
					ex.status = STS_INV_OP;
				end
			endcase
		end
	end

endmodule

FILE: rtl/load_store_cpu_execute_unit_core.sv
// ----------------------------------------------------------------------------
// load_store_cpu_execute_unit_core
// Execute unit of a small load/store CPU: register file and data memory in
// synchronous RAMs, pc and halt flag in flops, one command beat at a time.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+---------------------------
//   cmd      | in  | cmd_valid, cmd_stall | cmd (action, insn, data)
//   rsp      | out | rsp_valid, rsp_stall | rsp (next_pc, status, read)
//
// Accept issues the register file (and data memory) read, the next cycle
// executes and writes back. lw adds a load state, its data memory read
// following the address add. Output register plus one hold slot, so a
// stalled rsp only delays completion. arst_n clears control, pc, halt flag
// and register valid bits; data memory is not cleared. DMEM_DEPTH must be
// a power of two; no check in the block. Addresses wrap, upper bits dropped.
// ----------------------------------------------------------------------------
module load_store_cpu_execute_unit_core #(
	parameter int DMEM_DEPTH = 1024,
	parameter int PC_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  lscpu_pkg::cmd_t   cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lscpu_pkg::rsp_t   rsp
);
	import lscpu_pkg::*;

	localparam int AW = $clog2(DMEM_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOAD, S_HOLD} state_t;

	state_t              state_q;
	cmd_t                cmd_s1;
	logic [PC_WIDTH-1:0] pc_q;
	logic                halted_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	rsp_t                hold_q;

	logic                accept;
	logic                is_exec;
	logic                rsp_free;
	logic                finish;
	rsp_t                res;

	logic [31:0]         rf_a;
	logic [31:0]         rf_b;
	logic                rf_we;
	logic [4:0]          rf_waddr;
	logic [31:0]         rf_wdata;
	logic [4:0]          rf_raddr_a;

	logic [AW-1:0]       dm_addr;
	logic                dm_we;
	logic                dm_re;
	logic [31:0]         dm_wdata;
	logic [31:0]         dm_rdata;

	logic [PC_WIDTH-1:0] pc_nx;
	exec_t               ex;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign is_exec   = (cmd_s1.action == ACT_EXEC);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// register file: reads at accept, writes on execute or load return
	assign rf_raddr_a = (cmd.action == ACT_RD_REG) ? cmd.reg_index
	                                               : cmd.instruction_word[25:21];
	assign rf_we    = ((state_q == S_EXEC) && is_exec && ex.rf_we) || (state_q == S_LOAD);
	assign rf_waddr = (state_q == S_LOAD) ? cmd_s1.instruction_word[20:16] : ex.rf_waddr;
	assign rf_wdata = (state_q == S_LOAD) ? dm_rdata : ex.rf_wdata;

	lscpu_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.raddr_a (rf_raddr_a),
		.raddr_b (cmd.instruction_word[20:16]),
		.rdata_a (rf_a),
		.rdata_b (rf_b),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata)
	);

	// data memory port: host accesses at accept, lw/sw in the execute cycle
	assign dm_addr  = (state_q == S_IDLE) ? AW'(cmd.mem_address) : AW'(ex.ea);
	assign dm_wdata = (state_q == S_IDLE) ? cmd.write_value : ex.dm_wdata;
	assign dm_we    = (accept && (cmd.action == ACT_WR_MEM))
	               || ((state_q == S_EXEC) && is_exec && ex.dm_we);
	assign dm_re    = (accept && (cmd.action == ACT_RD_MEM))
	               || ((state_q == S_EXEC) && is_exec && ex.dm_re);

	lscpu_dmem #(
		.DEPTH (DMEM_DEPTH)
	) u_dmem (
		.clk   (clk),
		.addr  (dm_addr),
		.we    (dm_we),
		.wdata (dm_wdata),
		.re    (dm_re),
		.rdata (dm_rdata)
	);

	lscpu_alu #(
		.PC_WIDTH (PC_WIDTH)
	) u_alu (
		.word    (cmd_s1.instruction_word),
		.a       (rf_a),
		.b       (rf_b),
		.pc      (pc_q),
		.halted  (halted_q),
		.pc_next (pc_nx),
		.ex      (ex)
	);

	always_comb begin
		res        = '0;
		res.status = STS_OK;
		finish     = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (is_exec) begin
					finish      = !ex.dm_re;
					res.next_pc = ex.pc_we ? 16'(pc_nx) : 16'(pc_q);
					res.status  = ex.status;
				end else begin
					finish      = 1'b1;
					res.next_pc = 16'(pc_q);
					res.status  = halted_q ? STS_HALTED : STS_OK;
					if (cmd_s1.action == ACT_RD_MEM) begin
						res.read_value = dm_rdata;
					end else if (cmd_s1.action == ACT_RD_REG) begin
						res.read_value = rf_a;
					end
				end
			end
			S_LOAD: begin
				finish      = 1'b1;
				res.next_pc = 16'(pc_q);
			end
			S_HOLD: begin
				finish = 1'b1;
				res    = hold_q;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new beat may load in the cycle the old one leaves
			if (finish && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if ((state_q == S_EXEC) && is_exec) begin
				if (ex.pc_we) begin
					pc_q <= pc_nx;
				end
				if (ex.set_halt) begin
					halted_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_LOAD, S_HOLD: begin
					if (!finish) begin
						state_q <= S_LOAD;
					end else if (rsp_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (finish) begin
			if (rsp_free) begin
				rsp_q <= res;
			end else begin
				hold_q <= res;
			end
		end
	end

endmodule

FILE: rtl/lscpu_checker.sv
// ----------------------------------------------------------------------------
// lscpu_checker
// Port-level checks of the execute unit: beat accounting, one command in
// flight, and the halt state seen on responses.
// ----------------------------------------------------------------------------
module lscpu_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input lscpu_pkg::rsp_t rsp
);
	import lscpu_pkg::*;

	logic        cmd_beat;
	logic        rsp_beat;
	logic [1:0]  pend_q;
	logic        halt_seen_q;
	logic [15:0] halt_pc_q;

	assign cmd_beat = cmd_valid && !cmd_stall;
	assign rsp_beat = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			halt_seen_q <= 1'b0;
			halt_pc_q   <= '0;
		end else begin
			pend_q <= pend_q + 2'(cmd_beat) - 2'(rsp_beat);
			if (rsp_beat && (rsp.status == STS_HALTED) && !halt_seen_q) begin
				halt_seen_q <= 1'b1;
				halt_pc_q   <= rsp.next_pc;
			end
		end
	end

	// a response never appears without a command behind it
	a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0))
		else $error("response without outstanding command");

	// at most one command in execution plus one waiting response
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many outstanding commands");

	// one command at a time: accept is followed by a stalled cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat |=> cmd_stall)
		else $error("command accepted back to back");

	// once halted, every response reports halt at the same pc
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && halt_seen_q) |->
			((rsp.status == STS_HALTED) && (rsp.next_pc == halt_pc_q)))
		else $error("response after halt not halted");

	// protocol: a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind load_store_cpu_execute_unit_core lscpu_checker u_lscpu_checker (.*);
